// File: hw/rtl/nsc_pkg.sv
// ----------------------------------------------------------------------------
// NMEA sentence checksum checker package
// Shared types, character codes and the hex digit decode.
// ----------------------------------------------------------------------------
package nsc_pkg;

  // Characters that frame a sentence.
  localparam logic [7:0] StartMark = 8'd36;  // '$'
  localparam logic [7:0] StarMark  = 8'd42;  // '*'
  localparam logic [7:0] DigitNine = 8'd57;  // '9'
  localparam logic [7:0] DigitZero = 8'd48;  // '0'
  localparam logic [7:0] AlphaGap  = 8'd7;   // distance from ':' to 'A'

  localparam int unsigned TitleBytes = 5;
  localparam int unsigned TitleW     = 8 * TitleBytes;
  localparam int unsigned TitleLenW  = $clog2(TitleBytes + 1);

  // Titles of interest, earliest character in the high byte.
  localparam logic [TitleW-1:0] TitlePzmae = 40'h505A4D4145;
  localparam logic [TitleW-1:0] TitlePzmaf = 40'h505A4D4146;
  localparam logic [TitleW-1:0] TitlePzmag = 40'h505A4D4147;

  typedef enum logic [1:0] {
    PhHunt = 2'd0,
    PhBody = 2'd1,
    PhHex1 = 2'd2,
    PhHex2 = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    TypePzmae = 2'd0,
    TypePzmaf = 2'd1,
    TypePzmag = 2'd2
  } sentence_type_e;

  typedef struct packed {
    logic           valid;
    sentence_type_e sentence_type;
    logic           checksum_ok;
    logic [7:0]     computed_checksum;
  } result_t;

  // Decode one checksum character: subtract '0', and a further 7 above '9'.
  // Any byte value is accepted, so the result is a signed 9-bit quantity.
  function automatic logic signed [8:0] hex_value(input logic [7:0] c);
    logic signed [8:0] v;
    v = $signed({1'b0, c}) - $signed({1'b0, DigitZero});
    if (c > DigitNine) begin
      v = v - $signed({1'b0, AlphaGap});
    end
    return v;
  endfunction

endpackage

// File: hw/rtl/nsc_parser.sv
// ----------------------------------------------------------------------------
// NMEA sentence parser
// Sentence framing state, running XOR, title capture and checksum compare.
// ----------------------------------------------------------------------------
module nsc_parser (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,      // a byte is consumed this cycle
  input  logic [7:0]       byte_i,
  output nsc_pkg::result_t result_o   // not gated: use only with en_i high
);
  import nsc_pkg::*;

  phase_e                phase_q, phase_d;
  logic [7:0]            xor_q, xor_d;
  logic [TitleW-1:0]     title_q, title_d;
  logic [TitleLenW-1:0]  len_q, len_d;
  logic [7:0]            hex1_q, hex1_d;

  logic signed [8:0]     hi_val, lo_val;
  logic signed [12:0]    sent_val;
  logic                  sum_match;

  assign hi_val    = hex_value(hex1_q);
  assign lo_val    = hex_value(byte_i);
  assign sent_val  = $signed({hi_val, 4'b0000}) + $signed({{4{lo_val[8]}}, lo_val});
  assign sum_match = (sent_val == $signed({5'b00000, xor_q}));

  always_comb begin
    phase_d  = phase_q;
    xor_d    = xor_q;
    title_d  = title_q;
    len_d    = len_q;
    hex1_d   = hex1_q;
    result_o = '0;
    result_o.checksum_ok       = sum_match;
    result_o.computed_checksum = xor_q;

    unique case (phase_q)
      PhHunt: begin
        if (byte_i == StartMark) begin
          phase_d = PhBody;
          xor_d   = '0;
          title_d = '0;
          len_d   = '0;
        end
      end
      PhBody: begin
        if (byte_i == StarMark) begin
          phase_d = PhHex1;
        end else begin
          xor_d = xor_q ^ byte_i;
          if (len_q < TitleLenW'(TitleBytes)) begin
            title_d = {title_q[TitleW-9:0], byte_i};
            len_d   = len_q + TitleLenW'(1);
          end
        end
      end
      PhHex1: begin
        hex1_d  = byte_i;
        phase_d = PhHex2;
      end
      PhHex2: begin
        phase_d = PhHunt;
        if (len_q == TitleLenW'(TitleBytes)) begin
          priority if (title_q == TitlePzmae) begin
            result_o.valid         = 1'b1;
            result_o.sentence_type = TypePzmae;
          end else if (title_q == TitlePzmaf) begin
            result_o.valid         = 1'b1;
            result_o.sentence_type = TypePzmaf;
          end else if (title_q == TitlePzmag) begin
            result_o.valid         = 1'b1;
            result_o.sentence_type = TypePzmag;
          end else begin
            result_o.valid = 1'b0;
          end
        end
      end
      default: begin
        phase_d = PhHunt;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHunt;
      xor_q   <= '0;
      title_q <= '0;
      len_q   <= '0;
      hex1_q  <= '0;
    end else if (en_i) begin
      phase_q <= phase_d;
      xor_q   <= xor_d;
      title_q <= title_d;
      len_q   <= len_d;
      hex1_q  <= hex1_d;
    end
  end

endmodule

// File: hw/rtl/nmea_sentence_checksum_checker.sv
// ----------------------------------------------------------------------------
// NMEA sentence checksum checker
// Frames '$'...'*hh' sentences from a byte stream and reports known titles.
// ----------------------------------------------------------------------------
// Received characters enter one word per cycle on the slave stream, while no
// result waits on the master side. Bytes are dropped until a '$' opens a
// sentence; every byte up to the next '*' is XORed into a running checksum
// and the first five form the title. The two characters after '*' are
// decoded as upper-case hex and compared with the XOR. When the title is
// PZMAE, PZMAF or PZMAG one word leaves on the master stream carrying the
// title type, the pass flag and the computed XOR; other sentences, and
// sentences with a title shorter than five characters, leave nothing. The
// block sustains one input word per clock cycle while the master side takes
// its results. A result word is offered once the closing checksum character
// has passed through the input register and the parser's verdict has been
// loaded into the result register. Back-pressure on the master side holds
// the result register, and the input register stalls only while that result
// waits.
module nmea_sentence_checksum_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream: received characters.
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // Master stream: sentence results.
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o    // [1:0] sentence_type, [2] checksum_ok,
                                        // [10:3] computed_checksum, [15:11] zero
);
  import nsc_pkg::*;

  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       out_valid_q;
  logic [1:0] out_type_q;
  logic       out_ok_q;
  logic [7:0] out_sum_q;
  logic       advance;
  logic       consume;
  result_t    result;

  // The pipeline moves whenever the result register is empty or being drained.
  assign advance         = !out_valid_q || m_axis_tready_i;
  assign consume         = in_valid_q && advance;
  assign s_axis_tready_o = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  nsc_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (consume),
    .byte_i   (in_byte_q),
    .result_o (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= consume && result.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (consume && result.valid) begin
      out_type_q <= result.sentence_type;
      out_ok_q   <= result.checksum_ok;
      out_sum_q  <= result.computed_checksum;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {5'b00000, out_sum_q, out_ok_q, out_type_q};

endmodule

// File: hw/rtl/nsc_checker.sv
// ----------------------------------------------------------------------------
// NMEA sentence checksum checker port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module nsc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [7:0]  s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [15:0] m_axis_tdata_o
);

  // A result word stays offered until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result word withdrawn before it was taken");

  // A stalled result word holds its contents.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o))
    else $error("stalled result word changed");

  // Only the three known titles are reported, and the padding stays zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[1:0] != 2'd3) && (m_axis_tdata_o[15:11] == 5'd0))
    else $error("result word has an illegal type or non-zero padding");

  // A fresh result word follows a character accepted on the slave stream.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(s_axis_tvalid_i && s_axis_tready_o, 2))
    else $error("result word appeared without a closing character");

endmodule

bind nmea_sentence_checksum_checker nsc_checker u_nsc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// File: tb/nmea_sentence_checksum_checker_tb.sv
// ----------------------------------------------------------------------------
// NMEA sentence checksum checker testbench
// Feeds framed and broken '$...*hh' character streams through the checker and
// compares every reported sentence with a cycle-free tracker of the framing.
// ----------------------------------------------------------------------------
// A short scripted run opens the test: one byte outside any sentence, a short
// title carrying the extreme byte values, and one sentence of each known
// title, with the checksum good, broken by a lower-case non-hex letter, or
// broken by a start mark. After that the stimulus is random and made mostly of well-formed
// sentences: known titles, near misses, short and foreign titles, good and
// bad checksums, with line ends, noise and cut-off sentences in between.
// Both stream sides idle in random bursts, and the receiver holds off once
// for long enough that the checker fills up and stalls its input.
module nmea_sentence_checksum_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import nsc_pkg::*;

  localparam int RandomWords   = 700;
  localparam int HoldOffCycles = 300;
  localparam int DrainCycles   = 8;
  // The slowest correct run, long hold-off included, never goes this long
  // without a handshake, so this leaves a wide margin.
  localparam int StallLimit    = 2000;

  localparam logic [7:0] CarriageReturn = 8'h0D;
  localparam logic [7:0] LineFeed       = 8'h0A;
  localparam logic [7:0] UpperBase      = 8'd55;  // 'A' minus ten
  localparam logic [7:0] LowerBase      = 8'd87;  // 'a' minus ten
  localparam logic [7:0] PlusSign       = 8'h2B;

  // How the expectation of a scripted word is found: from the tracker, typed
  // in as no report at all, or typed in as a given report.
  typedef enum logic [1:0] {
    RowModel,
    RowNone,
    RowTyped
  } row_mode_e;

  typedef struct packed {
    sentence_type_e kind;
    logic           ok;
    logic [7:0]     xsum;
  } sentence_rec_t;

  // Text of one scripted line, right-aligned, and the expectation of its
  // last character. Every other character goes through the tracker.
  typedef struct packed {
    logic [79:0]   text;
    logic [3:0]    len;
    row_mode_e     last;
    sentence_rec_t want;
  } script_row_t;

  // The XOR of PZMAE is 43h; PZMAF gives 40h and PZMAG 41h.
  localparam script_row_t Script [5] = '{
    '{80'h0A, 4'd1, RowNone, '{TypePzmae, 1'b0, 8'h00}},
    '{{8'h24, 8'h00, 8'hFF, "*FF"}, 4'd6, RowNone, '{TypePzmae, 1'b0, 8'h00}},
    '{"$PZMAE*43", 4'd9, RowTyped, '{TypePzmae, 1'b1, 8'h43}},
    '{"$PZMAF*4g", 4'd9, RowTyped, '{TypePzmaf, 1'b0, 8'h40}},
    '{"$PZMAG*$1", 4'd9, RowTyped, '{TypePzmag, 1'b0, 8'h41}}
  };

  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [7:0]  s_axis_tdata_i  = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;

  // Expectation mode travelling alongside the word on the slave stream.
  row_mode_e     word_mode = RowModel;
  sentence_rec_t word_want = '0;

  // Tracker state, at its reset values.
  phase_e            trk_phase = PhHunt;
  logic [7:0]        trk_xor   = '0;
  logic [TitleW-1:0] trk_title = '0;
  logic [2:0]        trk_len   = '0;
  logic [7:0]        trk_first = '0;

  sentence_rec_t sentence_reports_q[$];
  int words_in      = 0;
  int words_sent    = 0;
  int stall_cycles  = 0;
  int errors        = 0;
  bit quiet_tail    = 1'b0;
  bit sender_calm   = 1'b0;
  bit held_off      = 1'b0;

  always #1 clk_i = ~clk_i;

  nmea_sentence_checksum_checker i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  task automatic flag_error(input string what, input logic [15:0] got,
                            input logic [15:0] want);
    $display("ERROR %s: got 0x%0h, expected 0x%0h", what, got, want);
    errors++;
  endtask

  // Checksum character decode: '0' maps to zero, and anything above '9' is
  // pulled down a further seven, so only upper-case hex lands on 10..15.
  function automatic int digit_value(input logic [7:0] ch);
    int v;
    v = int'(ch) - int'(DigitZero);
    if (ch > DigitNine) begin
      v -= int'(AlphaGap);
    end
    return v;
  endfunction

  // Advances the tracker by one received character. Returns 1 when the
  // character closes a sentence with a known title, with the report in rec.
  function automatic bit track_byte(input logic [7:0] ch, output sentence_rec_t rec);
    int sent;
    bit hit;
    hit = 1'b0;
    rec = '0;
    case (trk_phase)
      PhHunt: begin
        if (ch == StartMark) begin
          trk_phase = PhBody;
          trk_xor   = '0;
          trk_title = '0;
          trk_len   = '0;
        end
      end
      PhBody: begin
        if (ch == StarMark) begin
          trk_phase = PhHex1;
        end else begin
          trk_xor ^= ch;
          if (trk_len < TitleBytes) begin
            trk_title = {trk_title[TitleW-9:0], ch};
            trk_len++;
          end
        end
      end
      PhHex1: begin
        trk_first = ch;
        trk_phase = PhHex2;
      end
      default: begin
        sent     = digit_value(trk_first) * 16 + digit_value(ch);
        rec.ok   = (sent == int'(trk_xor));
        rec.xsum = trk_xor;
        if (trk_len == TitleBytes) begin
          hit = 1'b1;
          case (trk_title)
            TitlePzmae: rec.kind = TypePzmae;
            TitlePzmaf: rec.kind = TypePzmaf;
            TitlePzmag: rec.kind = TypePzmag;
            default:    hit = 1'b0;
          endcase
        end
        trk_phase = PhHunt;
      end
    endcase
    return hit;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nibble, input bit lower);
    if (nibble < 4'd10) begin
      return DigitZero + 8'(nibble);
    end
    return (lower ? LowerBase : UpperBase) + 8'(nibble);
  endfunction

  // Any byte but the star, so that a sentence body runs on to its own star.
  function automatic logic [7:0] body_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    return (b == StarMark) ? PlusSign : b;
  endfunction

  // Offers one word on the slave stream, at times after a random gap, never
  // in a calm or quiet stretch, and returns at the edge where it is accepted.
  task automatic send_word(input logic [7:0] ch, input row_mode_e mode = RowModel,
                           input sentence_rec_t want = '0);
    if (!quiet_tail && !sender_calm && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= ch;
    word_mode       <= mode;
    word_want       <= want;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    words_sent++;
  endtask

  // Both stream sides are watched in one process: the report leaving at an
  // edge is checked before the character taken at the same edge is tracked,
  // so the outcome never hangs on the order of processes within a step.
  always @(posedge clk_i) begin : stream_watch
    sentence_rec_t rec;
    sentence_rec_t head;
    bit            hit;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        if (sentence_reports_q.size() == 0) begin
          flag_error("report with no sentence due", m_axis_tdata_o, '0);
        end else begin
          head = sentence_reports_q.pop_front();
          if (m_axis_tdata_o[1:0] !== head.kind) begin
            flag_error("sentence type", m_axis_tdata_o[1:0], head.kind);
          end
          if (m_axis_tdata_o[2] !== head.ok) begin
            flag_error("checksum pass flag", m_axis_tdata_o[2], head.ok);
          end
          if (m_axis_tdata_o[10:3] !== head.xsum) begin
            flag_error("computed checksum", m_axis_tdata_o[10:3], head.xsum);
          end
          if (m_axis_tdata_o[15:11] !== '0) begin
            flag_error("padding bits", m_axis_tdata_o[15:11], '0);
          end
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        words_in++;
        hit = track_byte(s_axis_tdata_i, rec);
        case (word_mode)
          RowModel: begin
            if (hit) begin
              sentence_reports_q.push_back(rec);
            end
          end
          RowTyped: begin
            sentence_reports_q.push_back(word_want);
          end
          default: ;
        endcase
      end
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
    end
  end

  // Receiver: random stalls, and one long hold-off once the run is under way,
  // so that a report sits waiting while the sender keeps offering characters.
  initial begin : report_sink
    wait (rst_ni);
    @(posedge clk_i);
    m_axis_tready_i <= 1'b1;
    forever begin
      @(posedge clk_i);
      if (!held_off && words_in >= 150) begin
        held_off = 1'b1;
        m_axis_tready_i <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end else if (!quiet_tail && $urandom_range(0, 11) == 0) begin
        m_axis_tready_i <= 1'b0;
        repeat ($urandom_range(1, 18)) @(posedge clk_i);
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    do @(posedge clk_i); while (stall_cycles < StallLimit);
    $display("nmea_sentence_checksum_checker_tb NOT OK");
    $finish;
  end

  initial begin : sentence_source
    script_row_t       row;
    logic [7:0]        body[$];
    logic [TitleW-1:0] title;
    logic [7:0]        sum;
    int                pick;
    int                k;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Scripted lines, first character first.
    foreach (Script[r]) begin
      row = Script[r];
      for (k = 0; k < row.len; k++) begin
        send_word(row.text[8 * (row.len - 1 - k) +: 8],
                  (k == row.len - 1) ? row.last : RowModel, row.want);
      end
    end

    // Random part. The last stretch runs without idling on either side.
    words_sent = 0;
    while (words_sent < RandomWords) begin
      quiet_tail  = (words_sent >= RandomWords * 17 / 20);
      sender_calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
        // Line noise; a stray start mark here opens a sentence of its own.
        repeat ($urandom_range(1, 6)) send_word(8'($urandom_range(0, 255)));
      end else if (pick == 1) begin
        // A sentence cut off before its star: the next start mark becomes body.
        send_word(StartMark);
        repeat ($urandom_range(0, 8)) send_word(8'($urandom_range(0, 255)));
      end else begin
        body.delete();
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          case (pick % 3)
            0:       title = TitlePzmae;
            1:       title = TitlePzmaf;
            default: title = TitlePzmag;
          endcase
          // Near miss: one title letter swapped for a random capital.
          if (pick == 6) begin
            title[8 * $urandom_range(0, 4) +: 8] = 8'($urandom_range(65, 90));
          end
          for (k = TitleBytes - 1; k >= 0; k--) begin
            body.push_back(title[8 * k +: 8]);
          end
        end else if (pick == 7) begin
          // Up to four random bytes; the random tail below may lengthen the title.
          repeat ($urandom_range(0, 4)) body.push_back(body_byte());
        end else begin
          repeat ($urandom_range(5, 8)) body.push_back(body_byte());
        end
        repeat ($urandom_range(0, 6)) body.push_back(body_byte());
        sum = '0;
        foreach (body[i]) begin
          sum ^= body[i];
        end

        send_word(StartMark);
        foreach (body[i]) begin
          send_word(body[i]);
        end
        send_word(StarMark);
        pick = $urandom_range(0, 9);
        if (pick <= 6) begin
          send_word(hex_char(sum[7:4], 1'b0));
          send_word(hex_char(sum[3:0], 1'b0));
        end else if (pick == 7) begin
          send_word(hex_char(sum[7:4], 1'b1));
          send_word(hex_char(sum[3:0], 1'b1));
        end else if (pick == 8) begin
          sum ^= 8'($urandom_range(1, 255));
          send_word(hex_char(sum[7:4], 1'b0));
          send_word(hex_char(sum[3:0], 1'b0));
        end else begin
          send_word(8'($urandom_range(0, 255)));
          send_word(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 1) == 1) begin
          send_word(CarriageReturn);
          send_word(LineFeed);
        end
      end
    end
    s_axis_tvalid_i <= 1'b0;

    // Let every awaited report come out, then keep watching the master stream
    // so that any report beyond those is flagged.
    while (sentence_reports_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) begin
      $display("nmea_sentence_checksum_checker_tb OK");
    end else begin
      $display("nmea_sentence_checksum_checker_tb NOT OK");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/nsc_pkg.sv
hw/rtl/nsc_parser.sv
hw/rtl/nmea_sentence_checksum_checker.sv
hw/rtl/nsc_checker.sv
tb/nmea_sentence_checksum_checker_tb.sv
